// ===== hw/rtl/ual_pkg.sv =====
// Shared widths, codes and the command/status bundles of the unordered array list.
`default_nettype none

package ual_pkg;

   localparam int CMD_W    = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_READ   = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_FULL  = 3'd1,
      ST_EMPTY = 3'd2,
      ST_MISS  = 3'd3,
      ST_RANGE = 3'd4
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_req;
      logic       addr_from_req;
      logic       append_wr;
      logic       shift_wr;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       cnt_clr;
      logic       idx_clr;
      logic       idx_inc;
      logic       status_wr;
      status_type status_code;
      logic       data_take;
      logic       rsp_load;
   } dp_ctrl_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
      logic    pos_ok;
      logic    match;
      logic    last;
      logic    rsp_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/unordered_array_list.sv =====
// Top level of the unordered array list: controller plus datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------
//   request  | req_valid / req_stall | req_command, req_value, req_position
//   response | rsp_valid / rsp_stall | rsp_status, rsp_read_value, rsp_count
//
// One request at a time. Append, clear and refused commands go from decode
// straight to the finish state; a read first passes the wait state for the RAM
// data. Remove scans the entry RAM one word a cycle and then moves the later
// words down one a cycle, paced by the single read and write port of the RAM.
// Synchronous reset empties the list; entries are not cleared (no pass needed).
// A finished response sits in an output register, so the next request can be
// taken while the last response is still stalled.
`default_nettype none

module unordered_array_list #(
   parameter int CAPACITY = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [ual_pkg::CMD_W-1:0]   req_command,
   input  wire logic [ual_pkg::VALUE_W-1:0] req_value,
   input  wire logic [ual_pkg::POS_W-1:0]   req_position,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [ual_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ual_pkg::VALUE_W-1:0]      rsp_read_value,
   output logic [ual_pkg::COUNT_W-1:0]      rsp_count
);

   ual_pkg::dp_ctrl_type ctl;   // sequencing commands
   ual_pkg::dp_stat_type stat;  // flags the sequencer branches on

   // sequencer: decodes the request, steps scan and compaction, hands off response
   ual_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   // datapath: entry RAM, fill count, match logic, response register
   ual_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_value      (req_value),
      .req_position   (req_position),
      .ctl            (ctl),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/ual_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ual_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ual_ctrl.sv =====
// Sequencing state machine for the unordered array list.
`default_nettype none

module ual_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire ual_pkg::dp_stat_type stat,
   output ual_pkg::dp_ctrl_type      ctl
);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_DECIDE  = 6'b000010,
      S_RD_WAIT = 6'b000100,
      S_SCAN    = 6'b001000,
      S_SHIFT   = 6'b010000,
      S_FINISH  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            ctl.status_wr = 1'b1;
            unique case (stat.cmd)
               ual_pkg::CMD_APPEND: begin
                  if (stat.full) begin
                     ctl.status_code = ual_pkg::ST_FULL;
                  end else begin
                     ctl.status_code = ual_pkg::ST_OK;
                     ctl.append_wr   = 1'b1;
                     ctl.cnt_inc     = 1'b1;
                  end
                  state_in = S_FINISH;
               end
               ual_pkg::CMD_CLEAR: begin
                  ctl.status_code = ual_pkg::ST_OK;
                  ctl.cnt_clr     = 1'b1;
                  state_in        = S_FINISH;
               end
               ual_pkg::CMD_READ: begin
                  priority if (stat.empty) begin
                     ctl.status_code = ual_pkg::ST_EMPTY;
                     state_in        = S_FINISH;
                  end else if (!stat.pos_ok) begin
                     ctl.status_code = ual_pkg::ST_RANGE;
                     state_in        = S_FINISH;
                  end else begin
                     ctl.status_code   = ual_pkg::ST_OK;
                     ctl.addr_from_req = 1'b1;
                     state_in          = S_RD_WAIT;
                  end
               end
               ual_pkg::CMD_REMOVE: begin
                  if (stat.empty) begin
                     ctl.status_code = ual_pkg::ST_EMPTY;
                     state_in        = S_FINISH;
                  end else begin
                     ctl.status_code   = ual_pkg::ST_MISS;
                     ctl.addr_from_req = 1'b1;
                     ctl.idx_clr       = 1'b1;
                     state_in          = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_RD_WAIT: begin
            ctl.data_take = 1'b1;
            state_in      = S_FINISH;
         end
         S_SCAN: begin
            if (stat.match) begin
               ctl.status_wr   = 1'b1;
               ctl.status_code = ual_pkg::ST_OK;
               if (stat.last) begin
                  ctl.cnt_dec = 1'b1;
                  state_in    = S_FINISH;
               end else begin
                  ctl.idx_inc = 1'b1;
                  state_in    = S_SHIFT;
               end
            end else if (stat.last) begin
               state_in = S_FINISH;
            end else begin
               ctl.idx_inc = 1'b1;
            end
         end
         S_SHIFT: begin
            ctl.shift_wr = 1'b1;
            ctl.idx_inc  = 1'b1;
            if (stat.last) begin
               ctl.cnt_dec = 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> stat.rsp_free)
      else $error("response loaded over an untaken one");

   a_accept_decides: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DECIDE))
      else $error("accepted request not decoded");

endmodule

`default_nettype wire

// ===== hw/rtl/ual_dp.sv =====
// Datapath: entry store, fill count, scan index and response register.
`default_nettype none

module ual_dp #(
   parameter int CAPACITY = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ual_pkg::CMD_W-1:0]     req_command,
   input  wire logic [ual_pkg::VALUE_W-1:0]   req_value,
   input  wire logic [ual_pkg::POS_W-1:0]     req_position,
   input  wire ual_pkg::dp_ctrl_type          ctl,
   output ual_pkg::dp_stat_type               stat,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ual_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ual_pkg::VALUE_W-1:0]        rsp_read_value,
   output logic [ual_pkg::COUNT_W-1:0]        rsp_count
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > ual_pkg::POS_W) ? CNT_W : ual_pkg::POS_W;

   // float equality: signed zeros match, NaN matches nothing
   function automatic logic words_equal(input logic [31:0] a, input logic [31:0] b);
      logic a_nan;
      logic b_nan;
      logic zeros;
      a_nan = (a[30:0] > 31'h7F80_0000);
      b_nan = (b[30:0] > 31'h7F80_0000);
      zeros = ((a[30:0] | b[30:0]) == 31'd0);
      return !a_nan && !b_nan && (zeros || (a == b));
   endfunction

   ual_pkg::cmd_type              cmd_ff;
   logic [ual_pkg::VALUE_W-1:0]   value_ff;
   logic [ual_pkg::POS_W-1:0]     pos_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   ual_pkg::status_type           status_ff;
   logic [ual_pkg::VALUE_W-1:0]   data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ual_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [ual_pkg::VALUE_W-1:0]   rsp_value_ff;
   logic [ual_pkg::COUNT_W-1:0]   rsp_count_ff;

   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic [ual_pkg::VALUE_W-1:0]   wr_data;
   logic [IDX_W-1:0]              rd_addr;
   logic [ual_pkg::VALUE_W-1:0]   rd_data;
   logic                          full;

   // entry store
   assign wr_en   = ctl.append_wr || ctl.shift_wr;
   assign wr_addr = ctl.shift_wr ? IDX_W'(idx_ff - IDX_W'(1)) : IDX_W'(count_ff);
   assign wr_data = ctl.shift_wr ? rd_data : value_ff;

   always_comb begin
      if (ctl.addr_from_req) begin
         rd_addr = (cmd_ff == ual_pkg::CMD_REMOVE) ? '0
                 : IDX_W'(pos_ff - ual_pkg::POS_W'(1));
      end else begin
         rd_addr = IDX_W'(idx_ff + IDX_W'(1));   // read one ahead of the index
      end
   end

   ual_ram #(
      .WIDTH (ual_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // fill count, index and response valid
   always_comb begin
      priority if (ctl.cnt_clr) begin
         count_in = '0;
      end else if (ctl.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end

      priority if (ctl.idx_clr) begin
         idx_in = '0;
      end else if (ctl.idx_inc) begin
         idx_in = IDX_W'(idx_ff + IDX_W'(1));
      end else begin
         idx_in = idx_ff;
      end

      priority if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (ctl.load_req) begin
         cmd_ff   <= ual_pkg::cmd_type'(req_command);
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      if (ctl.load_req) begin
         data_ff <= '0;
      end else if (ctl.data_take) begin
         data_ff <= rd_data;
      end
      if (ctl.status_wr) begin
         status_ff <= ctl.status_code;
      end
      if (ctl.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= data_ff;
         rsp_count_ff  <= ual_pkg::COUNT_W'(count_ff);
      end
   end

   // status back to the controller
   assign full = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      stat.cmd      = cmd_ff;
      stat.full     = full;
      stat.empty    = (count_ff == '0);
      stat.pos_ok   = (pos_ff != '0) && (CMP_W'(pos_ff) <= CMP_W'(count_ff));
      stat.match    = words_equal(rd_data, value_ff);
      stat.last     = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
      stat.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_count      = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_shift_dest: assert property (@(posedge clock) disable iff (reset)
      ctl.shift_wr |-> (idx_ff != '0))
      else $error("compaction write below entry zero");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      ctl.append_wr |-> !full)
      else $error("append into a full list");

endmodule

`default_nettype wire
